/* rtl/bso_pkg.sv */
// Shared widths, types and codes of the box and ball overlap test.
package bso_pkg;

    // Component width and axis fraction bits of the fixed-point format
    localparam int CB        = 21;
    localparam int AF        = 19;
    localparam int PACK_W    = 3 * CB;
    localparam int RAD_W     = 20;
    localparam int DW        = CB + 1;      // centre difference
    localparam int AXW       = CB + 2;      // any test axis, cross axes included
    localparam int NVEC      = 6;           // three query axes, then three part axes
    localparam int NAXES     = 15;
    localparam int CFG_IDX_W = 3;
    localparam int PIPE_DEPTH = 6;

    typedef logic signed [CB-1:0]  comp_t;
    typedef logic        [CB-1:0]  size_t;
    typedef logic signed [DW-1:0]  diff_t;
    typedef logic signed [AXW-1:0] axis_t;

    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
    } lane_load_t;

    typedef enum logic [1:0] {
        PK_BOX_BOX,
        PK_BALL_BOX,
        PK_BALL_BALL
    } pair_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUERY_CENTRE,
        REG_QUERY_AXIS_FIRST,
        REG_QUERY_AXIS_SECOND,
        REG_QUERY_AXIS_THIRD,
        REG_QUERY_HALF_SIZE,
        REG_QUERY_IS_BALL,
        REG_QUERY_RADIUS
    } cfg_reg_t;

endpackage

/* rtl/bso_axis_lane.sv */
// One separating axis: projected centre offset against both box extents, three stages.
module bso_axis_lane (
    input  logic                clk,
    input  bso_pkg::lane_load_t ld,
    input  bso_pkg::diff_t      d  [3],
    input  bso_pkg::axis_t      ax [3],
    input  bso_pkg::comp_t      u  [bso_pkg::NVEC][3],
    input  bso_pkg::size_t      h  [bso_pkg::NVEC],
    output logic                sep
);
    import bso_pkg::*;

    localparam int DPW   = DW + AXW;
    localparam int PJW   = DPW + 2;
    localparam int UPW   = CB + AXW;
    localparam int USW   = UPW + 2;
    localparam int RW    = USW + 1 - AF;
    localparam int EXP_W = RW + CB;
    localparam int EXS_W = EXP_W + 3;
    localparam logic [USW:0] U_HALF = (USW + 1)'(1) << (AF - 1);

    logic signed [DPW-1:0] dp_next [3];
    logic signed [DPW-1:0] dp_reg  [3];
    logic signed [UPW-1:0] up_next [NVEC][3];
    logic signed [UPW-1:0] up_reg  [NVEC][3];
    size_t                 h3_reg  [NVEC];
    logic                  zero_next, zero3_reg;

    logic [PJW-1:0]        proj_next, proj4_reg;
    logic [RW-1:0]         rk_next [NVEC];
    logic [RW-1:0]         rk_reg  [NVEC];
    size_t                 h4_reg  [NVEC];
    logic                  zero4_reg;

    logic [PJW-1:0]        proj5_reg;
    logic [EXP_W-1:0]      ext_next [NVEC];
    logic [EXP_W-1:0]      ext_reg  [NVEC];
    logic                  zero5_reg;
    logic [EXS_W-1:0]      ext_sum;

    // products of the axis with the offset and with every box axis
    always_comb begin
        for (int m = 0; m < 3; m++) begin
            dp_next[m] = d[m] * ax[m];
            for (int v = 0; v < NVEC; v++) begin
                up_next[v][m] = u[v][m] * ax[m];
            end
        end
        zero_next = (ax[0] == '0) && (ax[1] == '0) && (ax[2] == '0);
    end

    always_ff @(posedge clk) begin
        if (ld.s3) begin
            dp_reg    <= dp_next;
            up_reg    <= up_next;
            h3_reg    <= h;
            zero3_reg <= zero_next;
        end
    end

    // sum, take magnitude, round extent factors
    always_comb begin
        logic signed [PJW-1:0] psum;
        logic signed [USW-1:0] usum;
        logic        [USW-1:0] umag;
        logic        [USW:0]   ur;
        psum = PJW'(dp_reg[0]) + PJW'(dp_reg[1]) + PJW'(dp_reg[2]);
        proj_next = psum[PJW-1] ? PJW'(-psum) : PJW'(psum);
        for (int v = 0; v < NVEC; v++) begin
            usum = USW'(up_reg[v][0]) + USW'(up_reg[v][1]) + USW'(up_reg[v][2]);
            umag = usum[USW-1] ? USW'(-usum) : USW'(usum);
            ur = {1'b0, umag} + U_HALF;
            rk_next[v] = ur[USW:AF];
        end
    end

    always_ff @(posedge clk) begin
        if (ld.s4) begin
            proj4_reg <= proj_next;
            rk_reg    <= rk_next;
            h4_reg    <= h3_reg;
            zero4_reg <= zero3_reg;
        end
    end

    always_comb begin
        for (int v = 0; v < NVEC; v++) begin
            ext_next[v] = rk_reg[v] * h4_reg[v];
        end
    end

    always_ff @(posedge clk) begin
        if (ld.s5) begin
            proj5_reg <= proj4_reg;
            ext_reg   <= ext_next;
            zero5_reg <= zero4_reg;
        end
    end

    // a degenerate cross axis never separates
    always_comb begin
        ext_sum = '0;
        for (int v = 0; v < NVEC; v++) begin
            ext_sum = ext_sum + EXS_W'(ext_reg[v]);
        end
        sep = !zero5_reg && (EXS_W'(proj5_reg) > ext_sum);
    end

endmodule

/* rtl/box_sphere_overlap_test.sv */
// Top level of the box and ball overlap test.
// Checks one query shape, written through the configuration port, against a
// stream of part shapes and returns one overlaps word per part word. Either
// shape is an oriented box (centre, three unit axes, half sizes) or a ball
// (centre, radius); touching counts as overlap. Box against box runs all
// fifteen separating axes in parallel lanes, ball against box clamps the
// ball centre into the box frame, ball against ball compares squared
// distance with the squared radius sum. The pipeline is six register stages
// deep, the last one being the output register: a part word taken at one
// edge loads the first stage and passes stages two to five into the output
// register for the sink. One part word is taken every cycle as long as the
// output side keeps up. A stall on the output only stops stages that are
// full, so bubbles get squeezed out before in_stall is raised.
// Write configuration only while no part is in flight.
module box_sphere_overlap_test (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bso_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bso_pkg::PACK_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bso_pkg::PACK_W-1:0]      part_centre,
    input  logic [bso_pkg::PACK_W-1:0]      part_axis_first,
    input  logic [bso_pkg::PACK_W-1:0]      part_axis_second,
    input  logic [bso_pkg::PACK_W-1:0]      part_axis_third,
    input  logic [bso_pkg::PACK_W-1:0]      part_half_size,
    input  logic                            part_is_ball,
    input  logic [bso_pkg::RAD_W-1:0]       part_radius,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            overlaps
);
    import bso_pkg::*;

    localparam int XW   = 2 * CB + 1;          // raw cross component
    localparam int SW   = DW + CB + 2;         // ball offset projection sum
    localparam int TW   = SW + 2 - AF;         // rounded ball offset
    localparam int EW   = CB + 4;              // outside distance
    localparam int DDW  = 2 * DW + 2;
    localparam int EESW = 2 * EW + 2;
    localparam int RSW  = RAD_W + 1;
    localparam logic [XW:0]         X_HALF     = (XW + 1)'(1) << (AF - 1);
    localparam logic [SW:0]         T_HALF     = (SW + 1)'(1) << (AF - 1);
    localparam logic [XW-AF:0]      CROSS_LIM  = (XW - AF + 1)'(1) << CB;
    localparam logic signed [TW:0]  E_LIM      = (TW + 1)'(1) << (CB + 2);

    typedef logic signed [2*CB-1:0]   prod_t;
    typedef logic signed [DW+CB-1:0]  bbp_t;

    // Round to nearest, halves away from zero, and saturate a cross component
    function automatic axis_t cross_round(input logic signed [XW-1:0] v);
        logic [XW-1:0]  mag;
        logic [XW:0]    rsum;
        logic [XW-AF:0] q;
        logic [AXW-1:0] qc;
        mag  = v[XW-1] ? XW'(-v) : XW'(v);
        rsum = {1'b0, mag} + X_HALF;
        q    = rsum[XW:AF];
        qc   = (q > CROSS_LIM) ? AXW'(CROSS_LIM) : AXW'(q);
        cross_round = v[XW-1] ? axis_t'(-qc) : axis_t'(qc);
    endfunction

    // ---------------------------------------------------------------
    // Query registers
    // ---------------------------------------------------------------
    logic [PACK_W-1:0] query_centre_reg, query_axis_first_reg, query_axis_second_reg;
    logic [PACK_W-1:0] query_axis_third_reg, query_half_size_reg;
    logic              query_is_ball_reg;
    logic [RAD_W-1:0]  query_radius_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            query_centre_reg      <= '0;
            query_axis_first_reg  <= '0;
            query_axis_second_reg <= '0;
            query_axis_third_reg  <= '0;
            query_half_size_reg   <= '0;
            query_is_ball_reg     <= 1'b0;
            query_radius_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_QUERY_CENTRE:      query_centre_reg      <= cfg_data;
                REG_QUERY_AXIS_FIRST:  query_axis_first_reg  <= cfg_data;
                REG_QUERY_AXIS_SECOND: query_axis_second_reg <= cfg_data;
                REG_QUERY_AXIS_THIRD:  query_axis_third_reg  <= cfg_data;
                REG_QUERY_HALF_SIZE:   query_half_size_reg   <= cfg_data;
                REG_QUERY_IS_BALL:     query_is_ball_reg     <= cfg_data[0];
                REG_QUERY_RADIUS:      query_radius_reg      <= cfg_data[RAD_W-1:0];
                default: ;             // drop writes past the last register
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Flow control: a stage advances when it is empty or the next one moves
    // ---------------------------------------------------------------
    logic [5:1] vld_reg;
    logic       out_valid_reg;
    logic [6:1] rdy;

    assign rdy[6] = !out_valid_reg || !out_stall;
    assign rdy[5] = !vld_reg[5] || rdy[6];
    assign rdy[4] = !vld_reg[4] || rdy[5];
    assign rdy[3] = !vld_reg[3] || rdy[4];
    assign rdy[2] = !vld_reg[2] || rdy[3];
    assign rdy[1] = !vld_reg[1] || rdy[2];
    assign in_stall  = !rdy[1];
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy[1]) vld_reg[1] <= in_valid;
            if (rdy[2]) vld_reg[2] <= vld_reg[1];
            if (rdy[3]) vld_reg[3] <= vld_reg[2];
            if (rdy[4]) vld_reg[4] <= vld_reg[3];
            if (rdy[5]) vld_reg[5] <= vld_reg[4];
            if (rdy[6]) out_valid_reg <= vld_reg[5];
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: unpack, centre differences, raw cross products
    // ---------------------------------------------------------------
    comp_t q_c [3];
    comp_t p_c [3];
    comp_t q_u [3][3];
    comp_t p_u [3][3];
    size_t q_h [3];
    size_t p_h [3];

    pair_kind_t       s1_kind_next, s1_kind_reg;
    diff_t            s1_d_next [3];
    diff_t            s1_d_reg  [3];
    diff_t            s1_dbb_next [3];
    diff_t            s1_dbb_reg  [3];
    comp_t            s1_boxu_next [3][3];
    comp_t            s1_boxu_reg  [3][3];
    size_t            s1_boxh_next [3];
    size_t            s1_boxh_reg  [3];
    comp_t            s1_u_next [NVEC][3];
    comp_t            s1_u_reg  [NVEC][3];
    size_t            s1_h_next [NVEC];
    size_t            s1_h_reg  [NVEC];
    logic [RAD_W-1:0] s1_r_next, s1_r_reg;
    logic [RSW-1:0]   s1_rs_next, s1_rs_reg;
    prod_t            s1_xp_next [3][3][3][2];
    prod_t            s1_xp_reg  [3][3][3][2];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            q_c[k]    = query_centre_reg[k*CB +: CB];
            q_u[0][k] = query_axis_first_reg[k*CB +: CB];
            q_u[1][k] = query_axis_second_reg[k*CB +: CB];
            q_u[2][k] = query_axis_third_reg[k*CB +: CB];
            q_h[k]    = query_half_size_reg[k*CB +: CB];
            p_c[k]    = part_centre[k*CB +: CB];
            p_u[0][k] = part_axis_first[k*CB +: CB];
            p_u[1][k] = part_axis_second[k*CB +: CB];
            p_u[2][k] = part_axis_third[k*CB +: CB];
            p_h[k]    = part_half_size[k*CB +: CB];
        end
    end

    always_comb begin
        int a;
        int b;
        if (query_is_ball_reg && part_is_ball)
            s1_kind_next = PK_BALL_BALL;
        else if (query_is_ball_reg || part_is_ball)
            s1_kind_next = PK_BALL_BOX;
        else
            s1_kind_next = PK_BOX_BOX;

        for (int k = 0; k < 3; k++) begin
            s1_d_next[k] = DW'(p_c[k]) - DW'(q_c[k]);
            if (query_is_ball_reg)
            begin
                s1_dbb_next[k]  = DW'(q_c[k]) - DW'(p_c[k]);
                s1_boxh_next[k] = p_h[k];
                for (int i = 0; i < 3; i++) s1_boxu_next[i][k] = p_u[i][k];
            end
            else
            begin
                s1_dbb_next[k]  = DW'(p_c[k]) - DW'(q_c[k]);
                s1_boxh_next[k] = q_h[k];
                for (int i = 0; i < 3; i++) s1_boxu_next[i][k] = q_u[i][k];
            end
        end
        s1_r_next  = query_is_ball_reg ? query_radius_reg : part_radius;
        s1_rs_next = RSW'(query_radius_reg) + RSW'(part_radius);

        for (int i = 0; i < 3; i++) begin
            s1_h_next[i]     = q_h[i];
            s1_h_next[i + 3] = p_h[i];
            for (int k = 0; k < 3; k++) begin
                s1_u_next[i][k]     = q_u[i][k];
                s1_u_next[i + 3][k] = p_u[i][k];
            end
        end

        // edge cross products, component m uses the two other components
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int m = 0; m < 3; m++) begin
                    a = (m == 2) ? 0 : m + 1;
                    b = (m == 0) ? 2 : m - 1;
                    s1_xp_next[i][j][m][0] = q_u[i][a] * p_u[j][b];
                    s1_xp_next[i][j][m][1] = q_u[i][b] * p_u[j][a];
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (rdy[1])
        begin
            s1_kind_reg <= s1_kind_next;
            s1_d_reg    <= s1_d_next;
            s1_dbb_reg  <= s1_dbb_next;
            s1_boxu_reg <= s1_boxu_next;
            s1_boxh_reg <= s1_boxh_next;
            s1_u_reg    <= s1_u_next;
            s1_h_reg    <= s1_h_next;
            s1_r_reg    <= s1_r_next;
            s1_rs_reg   <= s1_rs_next;
            s1_xp_reg   <= s1_xp_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: finish the fifteen axes, ball offset and distance products
    // ---------------------------------------------------------------
    pair_kind_t         s2_kind_reg;
    diff_t              s2_d_reg [3];
    comp_t              s2_u_reg [NVEC][3];
    size_t              s2_h_reg [NVEC];
    axis_t              s2_ax_next [NAXES][3];
    axis_t              s2_ax_reg  [NAXES][3];
    bbp_t               s2_bbp_next [3][3];
    bbp_t               s2_bbp_reg  [3][3];
    size_t              s2_boxh_reg [3];
    logic [RAD_W-1:0]   s2_r_reg;
    logic [2*DW-1:0]    s2_dd_next [3];
    logic [2*DW-1:0]    s2_dd_reg  [3];
    logic [2*RSW-1:0]   s2_rs2_next, s2_rs2_reg;

    always_comb begin
        for (int i = 0; i < NVEC; i++) begin
            for (int m = 0; m < 3; m++) s2_ax_next[i][m] = axis_t'(s1_u_reg[i][m]);
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int m = 0; m < 3; m++) begin
                    s2_ax_next[NVEC + 3*i + j][m] =
                        cross_round(XW'(s1_xp_reg[i][j][m][0]) - XW'(s1_xp_reg[i][j][m][1]));
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int m = 0; m < 3; m++) s2_bbp_next[i][m] = s1_dbb_reg[m] * s1_boxu_reg[i][m];
            s2_dd_next[i] = s1_d_reg[i] * s1_d_reg[i];
        end
        s2_rs2_next = s1_rs_reg * s1_rs_reg;
    end

    always_ff @(posedge clk) begin
        if (rdy[2])
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_d_reg    <= s1_d_reg;
            s2_u_reg    <= s1_u_reg;
            s2_h_reg    <= s1_h_reg;
            s2_ax_reg   <= s2_ax_next;
            s2_bbp_reg  <= s2_bbp_next;
            s2_boxh_reg <= s1_boxh_reg;
            s2_r_reg    <= s1_r_reg;
            s2_dd_reg   <= s2_dd_next;
            s2_rs2_reg  <= s2_rs2_next;
        end
    end

    // ---------------------------------------------------------------
    // Stages 3 to 5 of box against box: one lane per axis
    // ---------------------------------------------------------------
    lane_load_t         lane_ld;
    logic [NAXES-1:0]   lane_sep;

    assign lane_ld = '{s3: rdy[3], s4: rdy[4], s5: rdy[5]};

    for (genvar n = 0; n < NAXES; n++) begin : g_lane
        bso_axis_lane u_lane (
            .clk (clk),
            .ld  (lane_ld),
            .d   (s2_d_reg),
            .ax  (s2_ax_reg[n]),
            .u   (s2_u_reg),
            .h   (s2_h_reg),
            .sep (lane_sep[n])
        );
    end

    // ---------------------------------------------------------------
    // Stage 3: ball offset in the box frame, ball against ball compare
    // ---------------------------------------------------------------
    pair_kind_t               s3_kind_reg;
    logic signed [TW-1:0]     s3_t_next [3];
    logic signed [TW-1:0]     s3_t_reg  [3];
    size_t                    s3_boxh_reg [3];
    logic [2*RAD_W-1:0]       s3_rr_next, s3_rr_reg;
    logic                     s3_bbhit_next, s3_bbhit_reg;

    always_comb begin
        logic signed [SW-1:0] tsum;
        logic        [SW-1:0] tmag;
        logic        [SW:0]   tr;
        logic        [SW-AF:0] tq;
        logic        [DDW-1:0] ddsum;
        for (int i = 0; i < 3; i++) begin
            tsum = SW'(s2_bbp_reg[i][0]) + SW'(s2_bbp_reg[i][1]) + SW'(s2_bbp_reg[i][2]);
            tmag = tsum[SW-1] ? SW'(-tsum) : SW'(tsum);
            tr   = {1'b0, tmag} + T_HALF;
            tq   = tr[SW:AF];
            s3_t_next[i] = tsum[SW-1] ? -TW'(tq) : TW'(tq);
        end
        ddsum = DDW'(s2_dd_reg[0]) + DDW'(s2_dd_reg[1]) + DDW'(s2_dd_reg[2]);
        s3_bbhit_next = ddsum <= DDW'(s2_rs2_reg);
        s3_rr_next    = s2_r_reg * s2_r_reg;
    end

    always_ff @(posedge clk) begin
        if (rdy[3])
        begin
            s3_kind_reg  <= s2_kind_reg;
            s3_t_reg     <= s3_t_next;
            s3_boxh_reg  <= s2_boxh_reg;
            s3_rr_reg    <= s3_rr_next;
            s3_bbhit_reg <= s3_bbhit_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: distance outside the box along each box axis
    // ---------------------------------------------------------------
    pair_kind_t            s4_kind_reg;
    logic signed [EW-1:0]  s4_e_next [3];
    logic signed [EW-1:0]  s4_e_reg  [3];
    logic [2*RAD_W-1:0]    s4_rr_reg;
    logic                  s4_bbhit_reg;

    always_comb begin
        logic signed [TW-1:0] hs;
        logic signed [TW-1:0] cl;
        logic signed [TW:0]   ed;
        for (int i = 0; i < 3; i++) begin
            hs = TW'(s3_boxh_reg[i]);
            if (s3_t_reg[i] < -hs)
                cl = -hs;
            else if (s3_t_reg[i] > hs)
                cl = hs;
            else
                cl = s3_t_reg[i];
            ed = (TW + 1)'(s3_t_reg[i]) - (TW + 1)'(cl);
            if (ed > E_LIM)
                s4_e_next[i] = EW'(E_LIM);
            else if (ed < -E_LIM)
                s4_e_next[i] = EW'(-E_LIM);
            else
                s4_e_next[i] = EW'(ed);
        end
    end

    always_ff @(posedge clk) begin
        if (rdy[4])
        begin
            s4_kind_reg  <= s3_kind_reg;
            s4_e_reg     <= s4_e_next;
            s4_rr_reg    <= s3_rr_reg;
            s4_bbhit_reg <= s3_bbhit_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: square the outside distances
    // ---------------------------------------------------------------
    pair_kind_t          s5_kind_reg;
    logic [2*EW-1:0]     s5_ee_next [3];
    logic [2*EW-1:0]     s5_ee_reg  [3];
    logic [2*RAD_W-1:0]  s5_rr_reg;
    logic                s5_bbhit_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) s5_ee_next[i] = s4_e_reg[i] * s4_e_reg[i];
    end

    always_ff @(posedge clk) begin
        if (rdy[5])
        begin
            s5_kind_reg  <= s4_kind_reg;
            s5_ee_reg    <= s5_ee_next;
            s5_rr_reg    <= s4_rr_reg;
            s5_bbhit_reg <= s4_bbhit_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: pick the verdict for the shape pair, hold it for the sink
    // ---------------------------------------------------------------
    logic              overlaps_next, overlaps_reg;
    logic [EESW-1:0]   ee_sum;

    always_comb begin
        ee_sum = EESW'(s5_ee_reg[0]) + EESW'(s5_ee_reg[1]) + EESW'(s5_ee_reg[2]);
        case (s5_kind_reg)
            PK_BALL_BALL: overlaps_next = s5_bbhit_reg;
            PK_BALL_BOX:  overlaps_next = ee_sum <= EESW'(s5_rr_reg);
            default:      overlaps_next = !(|lane_sep);
        endcase
    end

    always_ff @(posedge clk) begin
        if (rdy[6]) overlaps_reg <= overlaps_next;
    end

    assign overlaps = overlaps_reg;

endmodule

/* rtl/bso_checker.sv */
// Port-level checks of the overlap test, bound to the top level.
module bso_checker (
    input logic clk,
    input logic rst_n,
    input logic cfg_valid,
    input logic cfg_ready,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic overlaps
);
    import bso_pkg::*;

    localparam int OCC_W = $clog2(PIPE_DEPTH + 1) + 1;

    logic [OCC_W-1:0] occ_reg, occ_next;

    // count words inside the block
    always_comb begin
        occ_next = occ_reg;
        if (in_valid && !in_stall)   occ_next = occ_next + OCC_W'(1);
        if (out_valid && !out_stall) occ_next = occ_next - OCC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(overlaps))
        else $error("stalled result changed");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall && (occ_reg == OCC_W'(PIPE_DEPTH)))
        else $error("input stalled while pipeline has room");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occ_reg != '0)
        else $error("result without a pending part");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(PIPE_DEPTH))
        else $error("more words in flight than stages");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind box_sphere_overlap_test bso_checker u_bso_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .overlaps  (overlaps)
);
